[hdl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the prime doubling chain finder
// Holds the data width, the chain limit and the modular multiply request.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned MAX_TERMS = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned OUT_TDATA_W = 72;

  // A term above this value has no successor that fits in 64 bits.
  localparam logic [DATA_W-1:0] TERM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  // Operands of one modular product (x * y) mod m, with x below m.
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] m;
  } mm_req_t;

endpackage

[hdl/pdc_mulmod.sv]
// ----------------------------------------------------------------------------
// pdc_mulmod: shared modular multiplier
// Computes (x * y) mod m by double-and-add, one bit of y at a time.
// ----------------------------------------------------------------------------
module pdc_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pdc_pkg::mm_req_t          req,
  output logic                      done,
  output logic [pdc_pkg::DATA_W-1:0] res
);

  logic [pdc_pkg::DATA_W-1:0] acc;
  logic [pdc_pkg::DATA_W-1:0] xr;
  logic [pdc_pkg::DATA_W-1:0] yr;
  logic [pdc_pkg::DATA_W-1:0] mr;
  logic [5:0]                 cnt;
  logic                       phase;
  logic                       busy;
  logic [pdc_pkg::DATA_W:0]   sum;
  logic [pdc_pkg::DATA_W-1:0] sum_mod;

  // One modular add: doubling in the first phase, adding x in the second.
  always_comb begin
    if (phase) begin
      sum = {1'b0, acc} + {1'b0, xr};
    end else begin
      sum = {1'b0, acc} + {1'b0, acc};
    end
    if (sum >= {1'b0, mr}) begin
      sum_mod = pdc_pkg::DATA_W'(sum - {1'b0, mr});
    end else begin
      sum_mod = sum[pdc_pkg::DATA_W-1:0];
    end
  end

  assign res = acc;

  // Bit sequencer, most significant bit of y first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy  <= 1'b1;
          acc   <= '0;
          xr    <= req.x;
          yr    <= req.y;
          mr    <= req.m;
          cnt   <= '0;
          phase <= 1'b0;
        end
      end else begin
        acc <= sum_mod;
        if (!phase && yr[pdc_pkg::DATA_W-1]) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          yr    <= yr << 1;
          if (cnt == 6'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
      end
    end
  end

endmodule

[hdl/pdc_prime_test.sv]
// ----------------------------------------------------------------------------
// pdc_prime_test: primality sequencer
// Trial division by 2 to 37, then Miller-Rabin with bases 2 to 37, all on
// one shared modular multiplier.
// ----------------------------------------------------------------------------
module pdc_prime_test (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pdc_pkg::DATA_W-1:0] n_in,
  output logic                       done,
  output logic                       prime
);

  typedef enum logic [3:0] {
    S_IDLE, S_TD, S_TDW, S_MRSH, S_BASE, S_POW, S_PMW, S_PSW,
    S_CHK, S_SQ, S_SQW, S_NEXT
  } state_t;

  state_t                     state;
  logic [pdc_pkg::DATA_W-1:0] n;
  logic [5:0]                 d;
  logic [pdc_pkg::DATA_W-1:0] odd;
  logic [pdc_pkg::DATA_W-1:0] e;
  logic [pdc_pkg::DATA_W-1:0] acc;
  logic [pdc_pkg::DATA_W-1:0] b;
  logic [5:0]                 twos;
  logic [5:0]                 k;
  logic [3:0]                 bi;
  logic                       mm_start;
  pdc_pkg::mm_req_t           mm_req;
  logic                       mm_done;
  logic [pdc_pkg::DATA_W-1:0] mm_res;
  logic [11:0]                d_sq;
  logic [5:0]                 base;

  assign d_sq = {6'd0, d} * {6'd0, d};

  // Miller-Rabin bases, the primes from 2 to 37.
  always_comb begin
    case (bi)
      4'd0:    base = 6'd2;
      4'd1:    base = 6'd3;
      4'd2:    base = 6'd5;
      4'd3:    base = 6'd7;
      4'd4:    base = 6'd11;
      4'd5:    base = 6'd13;
      4'd6:    base = 6'd17;
      4'd7:    base = 6'd19;
      4'd8:    base = 6'd23;
      4'd9:    base = 6'd29;
      4'd10:   base = 6'd31;
      default: base = 6'd37;
    endcase
  end

  pdc_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .req   (mm_req),
    .done  (mm_done),
    .res   (mm_res)
  );

  // Test sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      prime    <= 1'b0;
      mm_start <= 1'b0;
    end else begin
      done     <= 1'b0;
      mm_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n <= n_in;
            d <= 6'd2;
            if (n_in < 64'd2) begin
              prime <= 1'b0;
              done  <= 1'b1;
            end else begin
              state <= S_TD;
            end
          end
        end
        S_TD: begin
          if ({52'd0, d_sq} > n) begin
            prime <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            mm_req   <= '{x: 64'd1, y: n, m: {58'd0, d}};
            mm_start <= 1'b1;
            state    <= S_TDW;
          end
        end
        S_TDW: begin
          if (mm_done) begin
            if (mm_res == '0) begin
              prime <= (n == {58'd0, d});
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (d == 6'd37) begin
              odd   <= n - 64'd1;
              twos  <= '0;
              state <= S_MRSH;
            end else begin
              d     <= d + 6'd1;
              state <= S_TD;
            end
          end
        end
        S_MRSH: begin
          // Split n - 1 into an odd part and a power of two.
          if (!odd[0]) begin
            odd  <= odd >> 1;
            twos <= twos + 6'd1;
          end else begin
            bi    <= '0;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          acc   <= 64'd1;
          b     <= {58'd0, base};
          e     <= odd;
          state <= S_POW;
        end
        S_POW: begin
          if (e == '0) begin
            state <= S_CHK;
          end else if (e[0]) begin
            mm_req   <= '{x: acc, y: b, m: n};
            mm_start <= 1'b1;
            state    <= S_PMW;
          end else begin
            mm_req   <= '{x: b, y: b, m: n};
            mm_start <= 1'b1;
            state    <= S_PSW;
          end
        end
        S_PMW: begin
          if (mm_done) begin
            acc      <= mm_res;
            mm_req   <= '{x: b, y: b, m: n};
            mm_start <= 1'b1;
            state    <= S_PSW;
          end
        end
        S_PSW: begin
          if (mm_done) begin
            b     <= mm_res;
            e     <= e >> 1;
            state <= S_POW;
          end
        end
        S_CHK: begin
          if (acc == 64'd1 || acc == n - 64'd1) begin
            state <= S_NEXT;
          end else begin
            k     <= 6'd1;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k >= twos) begin
            prime <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            mm_req   <= '{x: acc, y: acc, m: n};
            mm_start <= 1'b1;
            state    <= S_SQW;
          end
        end
        S_SQW: begin
          if (mm_done) begin
            acc <= mm_res;
            if (mm_res == n - 64'd1) begin
              state <= S_NEXT;
            end else begin
              k     <= k + 6'd1;
              state <= S_SQ;
            end
          end
        end
        S_NEXT: begin
          if (bi == 4'd11) begin
            prime <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            bi    <= bi + 4'd1;
            state <= S_BASE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/prime_doubling_chain_finder_core.sv]
// ----------------------------------------------------------------------------
// prime_doubling_chain_finder_core: follows the chain p, 2p+1, ... while prime
// Each chain term goes through the primality test, whose modular products all
// run one after another on the one shared modular multiplier.
// Throughput: one request at a time; the input is ready only when idle.
// Reset: synchronous, clears all control state and any pending result.
// ----------------------------------------------------------------------------
module prime_doubling_chain_finder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pdc_pkg::DATA_W-1:0]  s_tdata,  // start_value[63:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pdc_pkg::OUT_TDATA_W-1:0] m_tdata, // term[63:0], term_index[69:64], zeros
  output logic                        m_tuser,  // term_valid
  output logic                        m_tlast   // is_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_TEST, S_OUT, S_CONT
  } state_t;

  state_t                      state;
  state_t                      after;
  logic [pdc_pkg::DATA_W-1:0]  q;
  logic [pdc_pkg::IDX_W-1:0]   count;
  logic [pdc_pkg::DATA_W-1:0]  held_term;
  logic [pdc_pkg::IDX_W-1:0]   held_idx;
  logic [pdc_pkg::DATA_W-1:0]  out_term;
  logic [pdc_pkg::IDX_W-1:0]   out_idx;
  logic                        t_start;
  logic                        t_done;
  logic                        t_prime;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, out_idx, out_term};

  pdc_prime_test u_test (
    .clk   (clk),
    .rst   (rst),
    .start (t_start),
    .n_in  (q),
    .done  (t_done),
    .prime (t_prime)
  );

  // Chain sequencer; a result is held back until the next term's verdict
  // tells whether it is the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      after    <= S_IDLE;
      m_tvalid <= 1'b0;
      t_start  <= 1'b0;
    end else begin
      t_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            q     <= s_tdata;
            count <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          t_start <= 1'b1;
          state   <= S_TEST;
        end
        S_TEST: begin
          if (t_done) begin
            if (!t_prime) begin
              if (count == '0) begin
                out_term <= q;
                out_idx  <= '0;
                m_tuser  <= 1'b0;
              end else begin
                out_term <= held_term;
                out_idx  <= held_idx;
                m_tuser  <= 1'b1;
              end
              m_tlast  <= 1'b1;
              m_tvalid <= 1'b1;
              after    <= S_IDLE;
              state    <= S_OUT;
            end else if (count != '0) begin
              out_term <= held_term;
              out_idx  <= held_idx;
              m_tuser  <= 1'b1;
              m_tlast  <= 1'b0;
              m_tvalid <= 1'b1;
              after    <= S_CONT;
              state    <= S_OUT;
            end else begin
              state <= S_CONT;
            end
          end
        end
        S_CONT: begin
          // q is prime; stop at the term limit or before overflow.
          held_term <= q;
          held_idx  <= count;
          if (count == pdc_pkg::IDX_W'(pdc_pkg::MAX_TERMS - 1) ||
              q > pdc_pkg::TERM_LIMIT) begin
            out_term <= q;
            out_idx  <= count;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            m_tvalid <= 1'b1;
            after    <= S_IDLE;
            state    <= S_OUT;
          end else begin
            q     <= {q[pdc_pkg::DATA_W-2:0], 1'b1};
            count <= count + pdc_pkg::IDX_W'(1);
            state <= S_START;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= after;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/prime_doubling_chain_finder_core_tb.sv]
// ----------------------------------------------------------------------------
// prime_doubling_chain_finder_core_tb: self-checking bench for the chain finder
// Sends start values over the input stream. Each start value is a request. A
// behavioral predictor with exact 128-bit modular products works out every
// chain term, and the bench checks each result against the oldest expectation.
// Directed corner values come first, then random phases with idling and stalls.
// ----------------------------------------------------------------------------
module prime_doubling_chain_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pdc_pkg::DATA_W-1:0] term;
    logic [pdc_pkg::IDX_W-1:0]  term_index;
    logic                       term_valid;
    logic                       is_last;
  } chain_term_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pdc_pkg::DATA_W-1:0]      s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pdc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  chain_term_t pending_terms[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Start values of prime chains, several of them long, so that random traffic walks deep chains.
  logic [pdc_pkg::DATA_W-1:0] chain_starts[8] = '{64'd2, 64'd89, 64'd1122659, 64'd41,
                                                  64'd509, 64'd53, 64'd1031, 64'd2131};

  prime_doubling_chain_finder_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Exact (x * y) mod m through a 128-bit product.
  function automatic logic [pdc_pkg::DATA_W-1:0] prod_mod(logic [pdc_pkg::DATA_W-1:0] x,
                                                          logic [pdc_pkg::DATA_W-1:0] y,
                                                          logic [pdc_pkg::DATA_W-1:0] m);
    logic [127:0] full;
    full = {64'd0, x} * {64'd0, y};
    return 64'(full % {64'd0, m});
  endfunction

  function automatic logic [pdc_pkg::DATA_W-1:0] power_mod(logic [pdc_pkg::DATA_W-1:0] b,
                                                           logic [pdc_pkg::DATA_W-1:0] e,
                                                           logic [pdc_pkg::DATA_W-1:0] m);
    logic [pdc_pkg::DATA_W-1:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = prod_mod(acc, b, m);
      b = prod_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Trial division by 2..37, then Miller-Rabin with the bases 2..37.
  function automatic bit prime_check(logic [pdc_pkg::DATA_W-1:0] n);
    logic [pdc_pkg::DATA_W-1:0] d, odd, x, a;
    int unsigned twos, k;
    bit witness;
    logic [pdc_pkg::DATA_W-1:0] bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (n < 2) return 1'b0;
    for (d = 2; d < 38; d++) begin
      if (d * d > n) return 1'b1;
      if (n % d == 0) return n == d;
    end
    odd = n - 1;
    twos = 0;
    while (!odd[0]) begin
      odd = odd >> 1;
      twos++;
    end
    for (int i = 0; i < 12; i++) begin
      a = bases[i] % n;
      if (a == 0) continue;
      x = power_mod(a, odd, n);
      if (x == 1 || x == n - 1) continue;
      witness = 1'b1;
      for (k = 1; k < twos; k++) begin
        x = prod_mod(x, x, n);
        if (x == n - 1) begin
          witness = 1'b0;
          break;
        end
      end
      if (witness) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queues every term of the chain that begins at start, or one invalid term if start is not prime.
  task automatic predict_chain(logic [pdc_pkg::DATA_W-1:0] start);
    logic [pdc_pkg::DATA_W-1:0] q;
    int count;
    chain_term_t t;
    q = start;
    count = 0;
    while (count < pdc_pkg::MAX_TERMS && prime_check(q)) begin
      t = '{term: q, term_index: pdc_pkg::IDX_W'(count), term_valid: 1'b1, is_last: 1'b0};
      pending_terms.push_back(t);
      count++;
      if (q > pdc_pkg::TERM_LIMIT)
        break;
      q = {q[pdc_pkg::DATA_W-2:0], 1'b1};
    end
    if (count == 0) begin
      t = '{term: start, term_index: '0, term_valid: 1'b0, is_last: 1'b1};
      pending_terms.push_back(t);
    end else begin
      pending_terms[pending_terms.size() - 1].is_last = 1'b1;
    end
  endtask

  // Sends one start value, idling first as the current phase asks.
  task automatic send_start(logic [pdc_pkg::DATA_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 64'($urandom) << 32 | 64'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    predict_chain(value);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic end_burst_and_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    chain_term_t exp_t;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_terms.size() == 0) begin
        $error("unexpected result term=%0d", m_tdata[63:0]);
        error_count++;
      end else begin
        exp_t = pending_terms.pop_front();
        if (m_tdata[63:0] !== exp_t.term) begin
          $error("term: expected %0d, got %0d", exp_t.term, m_tdata[63:0]);
          error_count++;
        end
        if (m_tdata[69:64] !== exp_t.term_index) begin
          $error("term_index: expected %0d, got %0d", exp_t.term_index, m_tdata[69:64]);
          error_count++;
        end
        if (m_tuser !== exp_t.term_valid) begin
          $error("term_valid: expected %0b, got %0b", exp_t.term_valid, m_tuser);
          error_count++;
        end
        if (m_tlast !== exp_t.is_last) begin
          $error("is_last: expected %0b, got %0b", exp_t.is_last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Corner values: zero, one, small primes, pseudoprimes, the overflow guard.
  task automatic test_corner_values();
    logic [pdc_pkg::DATA_W-1:0] vals[$] = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37,
      64'd41, 64'd1369, 64'd1361, 64'd89, 64'd561, 64'd2047, 64'd1122659,
      64'd3215031751, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
      64'h7FFF_FFFF_FFFF_FFE7, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'hAAAA_AAAA_AAAA_AAAB, 64'h5555_5555_5555_5555};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (vals[i]) send_start(vals[i]);
    end_burst_and_drain();
  endtask

  // Mostly small values and known chain starts, a few full-width values.
  task automatic test_random_starts(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned count);
    logic [pdc_pkg::DATA_W-1:0] v;
    int unsigned r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) v = chain_starts[$urandom_range(7)];
      else if (r < 65) v = 64'($urandom_range(4095));
      else if (r < 80) v = 64'($urandom_range(24'hFF_FFFF));
      else v = {$urandom, $urandom} | 64'(r < 95);
      send_start(v);
    end
    end_burst_and_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_values();
    test_random_starts(0, 0, 25);
    test_random_starts(78, 0, 25);
    test_random_starts(0, 78, 25);
    test_random_starts(31, 31, 25);
    if (error_count == 0) begin
      $display("PASS prime_doubling_chain_finder_core");
    end else begin
      $display("FAIL prime_doubling_chain_finder_core");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #400ms;
    $display("FAIL prime_doubling_chain_finder_core");
    $finish;
  end

endmodule
